// ----- hdl/owbm_pkg.sv -----
// ----------------------------------------------------------------------------
// owbm_pkg: shared types and constants of the 1-Wire bus master
// Command and operation codes, register indexes, reset values and the
// item, result and configuration records passed between modules.
// ----------------------------------------------------------------------------
package owbm_pkg;

   localparam int CFG_W       = 10;
   localparam int CSR_INDEX_W = 3;
   localparam int BYTE_W      = 8;
   localparam int BIT_CNT_W   = 3;

   // command field codes
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_RESET = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_LOW     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRES_SAMPLE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_RELEASE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_LOW     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_SAMPLE   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT          = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECOVERY      = 3'd6;

   // register reset values (presence sample point 67.5 us rounded up)
   localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd490;
   localparam logic [CFG_W-1:0] RST_PRES_SAMPLE   = 10'd68;
   localparam logic [CFG_W-1:0] RST_RESET_RELEASE = 10'd490;
   localparam logic [CFG_W-1:0] RST_START_LOW     = 10'd2;
   localparam logic [CFG_W-1:0] RST_READ_SAMPLE   = 10'd4;
   localparam logic [CFG_W-1:0] RST_SLOT          = 10'd62;
   localparam logic [CFG_W-1:0] RST_RECOVERY      = 10'd2;

   localparam logic [BIT_CNT_W-1:0] LAST_BIT = 3'd7;

   typedef enum logic [1:0] {
      OP_IDLE  = 2'd0,
      OP_RESET = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PH_LOW  = 2'd0,
      PH_MID  = 2'd1,
      PH_TAIL = 2'd2
   } phase_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [BYTE_W-1:0] write_byte;
      logic              line_level;
   } item_type;

   typedef struct packed {
      logic              drive_low;
      logic              busy_res;
      logic              done_res;
      logic              presence;
      logic [BYTE_W-1:0] read_byte;
      logic              rejected;
   } result_type;

   typedef struct packed {
      logic [CFG_W-1:0] reset_low_ticks;
      logic [CFG_W-1:0] presence_sample_ticks;
      logic [CFG_W-1:0] reset_release_ticks;
      logic [CFG_W-1:0] start_low_ticks;
      logic [CFG_W-1:0] read_sample_ticks;
      logic [CFG_W-1:0] slot_ticks;
      logic [CFG_W-1:0] recovery_ticks;
   } cfg_type;

endpackage

// ----- hdl/owbm_if.sv -----
// ----------------------------------------------------------------------------
// owbm_req_if / owbm_rsp_if: valid/ready channels of the bus master
// Tick items in, one result per tick out.
// ----------------------------------------------------------------------------
interface owbm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] write_byte;
   logic       line_level;

   modport source (output valid, command, write_byte, line_level, input ready);
   modport sink   (input valid, command, write_byte, line_level, output ready);
endinterface

interface owbm_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic       presence;
   logic [7:0] read_byte;
   logic       rejected;

   modport source (output valid, drive_low, busy_res, done_res, presence, read_byte,
                   rejected, input ready);
   modport sink   (input valid, drive_low, busy_res, done_res, presence, read_byte,
                   rejected, output ready);
endinterface

// ----- hdl/owbm_csr.sv -----
// ----------------------------------------------------------------------------
// owbm_csr: timing register bank
// Seven write-only timing registers; writes beyond the list are dropped.
// ----------------------------------------------------------------------------
module owbm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [owbm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [owbm_pkg::CFG_W-1:0]       csr_write_data,
   output owbm_pkg::cfg_type                cfg
);

   owbm_pkg::cfg_type cfg_ff;
   owbm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            owbm_pkg::CSR_RESET_LOW:     cfg_in.reset_low_ticks       = csr_write_data;
            owbm_pkg::CSR_PRES_SAMPLE:   cfg_in.presence_sample_ticks = csr_write_data;
            owbm_pkg::CSR_RESET_RELEASE: cfg_in.reset_release_ticks   = csr_write_data;
            owbm_pkg::CSR_START_LOW:     cfg_in.start_low_ticks       = csr_write_data;
            owbm_pkg::CSR_READ_SAMPLE:   cfg_in.read_sample_ticks     = csr_write_data;
            owbm_pkg::CSR_SLOT:          cfg_in.slot_ticks            = csr_write_data;
            owbm_pkg::CSR_RECOVERY:      cfg_in.recovery_ticks        = csr_write_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks       <= owbm_pkg::RST_RESET_LOW;
         cfg_ff.presence_sample_ticks <= owbm_pkg::RST_PRES_SAMPLE;
         cfg_ff.reset_release_ticks   <= owbm_pkg::RST_RESET_RELEASE;
         cfg_ff.start_low_ticks       <= owbm_pkg::RST_START_LOW;
         cfg_ff.read_sample_ticks     <= owbm_pkg::RST_READ_SAMPLE;
         cfg_ff.slot_ticks            <= owbm_pkg::RST_SLOT;
         cfg_ff.recovery_ticks        <= owbm_pkg::RST_RECOVERY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/owbm_seq.sv -----
// ----------------------------------------------------------------------------
// owbm_seq: bus timing sequencer
// Holds operation, phase, tick timer, bit count and shift byte; advances
// them by one tick per step and forms that tick's result.
// ----------------------------------------------------------------------------
module owbm_seq #(
   parameter int TIMER_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  owbm_pkg::item_type     item,
   input  owbm_pkg::cfg_type      cfg,
   output owbm_pkg::result_type   result
);

   localparam int CMP_W = (TIMER_BITS > owbm_pkg::CFG_W) ? TIMER_BITS : owbm_pkg::CFG_W;

   owbm_pkg::op_type                  op_ff, op_in;
   owbm_pkg::phase_type               ph_ff, ph_in;
   logic [TIMER_BITS-1:0]             tm_ff, tm_in;
   logic [owbm_pkg::BIT_CNT_W-1:0]    bit_ff, bit_in;
   logic [owbm_pkg::BYTE_W-1:0]       sh_ff, sh_in;
   logic                              pr_ff, pr_in;

   logic [TIMER_BITS-1:0] len_reset_low, len_pres, len_release, len_start;
   logic [TIMER_BITS-1:0] len_read, len_slot, len_recovery;

   // zero acts as one (unless allowed), then saturate to the timer range
   function automatic logic [TIMER_BITS-1:0] eff_len(input logic [owbm_pkg::CFG_W-1:0] v,
                                                     input logic zero_ok);
      logic [CMP_W-1:0] v_w;
      logic [CMP_W-1:0] t_max;
      v_w   = CMP_W'(v);
      t_max = CMP_W'({TIMER_BITS{1'b1}});
      if (v_w == '0 && !zero_ok)
         v_w = CMP_W'(1);
      if (v_w > t_max)
         v_w = t_max;
      return v_w[TIMER_BITS-1:0];
   endfunction

   assign len_reset_low = eff_len(cfg.reset_low_ticks, 1'b0);
   assign len_pres      = eff_len(cfg.presence_sample_ticks, 1'b0);
   assign len_release   = eff_len(cfg.reset_release_ticks, 1'b0);
   assign len_start     = eff_len(cfg.start_low_ticks, 1'b0);
   assign len_read      = eff_len(cfg.read_sample_ticks, 1'b0);
   assign len_slot      = eff_len(cfg.slot_ticks, 1'b0);
   assign len_recovery  = eff_len(cfg.recovery_ticks, 1'b1);

   always_comb begin
      logic done;
      logic slot_end;
      op_in  = op_ff;
      ph_in  = ph_ff;
      tm_in  = tm_ff;
      bit_in = bit_ff;
      sh_in  = sh_ff;
      pr_in  = pr_ff;
      result = '0;
      done   = 1'b0;
      slot_end = 1'b0;

      if (op_ff != owbm_pkg::OP_IDLE && item.command != owbm_pkg::CMD_NONE)
         result.rejected = 1'b1;

      // start a new operation on this same tick
      if (op_ff == owbm_pkg::OP_IDLE && item.command != owbm_pkg::CMD_NONE) begin
         op_in  = owbm_pkg::op_type'(item.command);
         ph_in  = owbm_pkg::PH_LOW;
         tm_in  = '0;
         bit_in = '0;
         pr_in  = 1'b0;
         sh_in  = (item.command == owbm_pkg::CMD_WRITE) ? item.write_byte : '0;
      end

      if (op_in != owbm_pkg::OP_IDLE) begin
         result.busy_res = 1'b1;
         tm_in = tm_in + TIMER_BITS'(1);
         case (op_in)
            owbm_pkg::OP_RESET: begin
               if (ph_in == owbm_pkg::PH_LOW) begin
                  result.drive_low = 1'b1;
                  if (tm_in >= len_reset_low) begin
                     ph_in = owbm_pkg::PH_MID;
                     tm_in = '0;
                  end
               end else begin
                  if (tm_in == len_pres)
                     pr_in = ~item.line_level;
                  if (tm_in >= len_release) begin
                     done = 1'b1;
                     result.presence = pr_in;
                  end
               end
            end
            owbm_pkg::OP_WRITE: begin
               if (ph_in == owbm_pkg::PH_LOW) begin
                  result.drive_low = 1'b1;
                  if (tm_in >= len_start) begin
                     ph_in = owbm_pkg::PH_MID;
                     tm_in = '0;
                  end
               end else if (ph_in == owbm_pkg::PH_MID) begin
                  result.drive_low = ~sh_in[0];
                  if (tm_in >= len_slot) begin
                     sh_in = {1'b0, sh_in[owbm_pkg::BYTE_W-1:1]};
                     if (len_recovery == '0) begin
                        slot_end = 1'b1;
                     end else begin
                        ph_in = owbm_pkg::PH_TAIL;
                        tm_in = '0;
                     end
                  end
               end else begin
                  if (tm_in >= len_recovery)
                     slot_end = 1'b1;
               end
            end
            owbm_pkg::OP_READ: begin
               if (ph_in == owbm_pkg::PH_LOW) begin
                  result.drive_low = 1'b1;
                  if (tm_in >= len_start) begin
                     ph_in = owbm_pkg::PH_MID;
                     tm_in = '0;
                  end
               end else if (ph_in == owbm_pkg::PH_MID) begin
                  if (tm_in >= len_read) begin
                     // shift the sampled bit in at the top
                     sh_in = {item.line_level, sh_in[owbm_pkg::BYTE_W-1:1]};
                     ph_in = owbm_pkg::PH_TAIL;
                     tm_in = '0;
                  end
               end else begin
                  if (tm_in >= len_slot) begin
                     slot_end = 1'b1;
                     if (bit_in == owbm_pkg::LAST_BIT)
                        result.read_byte = sh_in;
                  end
               end
            end
            default: begin
               op_in = owbm_pkg::OP_IDLE;
            end
         endcase

         if (slot_end) begin
            if (bit_in == owbm_pkg::LAST_BIT) begin
               done = 1'b1;
            end else begin
               bit_in = bit_in + owbm_pkg::BIT_CNT_W'(1);
               ph_in  = owbm_pkg::PH_LOW;
               tm_in  = '0;
            end
         end

         if (done) begin
            op_in  = owbm_pkg::OP_IDLE;
            ph_in  = owbm_pkg::PH_LOW;
            tm_in  = '0;
            bit_in = '0;
         end
      end
      result.done_res = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff  <= owbm_pkg::OP_IDLE;
         ph_ff  <= owbm_pkg::PH_LOW;
         tm_ff  <= '0;
         bit_ff <= '0;
         sh_ff  <= '0;
         pr_ff  <= 1'b0;
      end else if (step) begin
         op_ff  <= op_in;
         ph_ff  <= ph_in;
         tm_ff  <= tm_in;
         bit_ff <= bit_in;
         sh_ff  <= sh_in;
         pr_ff  <= pr_in;
      end
   end

endmodule

// ----- hdl/one_wire_bus_master_unit.sv -----
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit: timed 1-Wire bus master
//
//   port       dir  handshake       carries
//   req_bus    in   valid/ready     command, write_byte, line_level (1 tick)
//   rsp_bus    out  valid/ready     drive_low, busy_res, done_res, presence,
//                                   read_byte, rejected (1 per tick)
//   csr_*      in   write enable    register index, 10-bit write data
//
// One tick item per clock cycle sustained while the result side is ready. A
// tick lands in the input register, the sequencer works it out in one pass
// and the result register presents it.
// Reset is synchronous; it restores the timing registers and leaves the
// sequencer idle. A stalled result holds its register and the input register
// still takes one more tick, then ready drops until the result moves.
// ----------------------------------------------------------------------------
module one_wire_bus_master_unit #(
   parameter int TIMER_BITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   owbm_req_if.sink                         req_bus,
   owbm_rsp_if.source                       rsp_bus,
   input  logic                             csr_write_enable,
   input  logic [owbm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [owbm_pkg::CFG_W-1:0]       csr_write_data
);

   owbm_pkg::cfg_type    cfg;
   owbm_pkg::item_type   in_item_ff, in_item_in;
   logic                 in_valid_ff, in_valid_in;
   owbm_pkg::result_type out_res_ff, out_res_in;
   logic                 out_valid_ff, out_valid_in;
   owbm_pkg::result_type step_res;
   logic                 advance;
   logic                 step;
   logic                 take;

   owbm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   owbm_seq #(
      .TIMER_BITS (TIMER_BITS)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (step_res)
   );

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign step          = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      in_item_in = in_item_ff;
      if (take) begin
         in_item_in.command    = req_bus.command;
         in_item_in.write_byte = req_bus.write_byte;
         in_item_in.line_level = req_bus.line_level;
      end
      in_valid_in = take ? 1'b1 : (step ? 1'b0 : in_valid_ff);

      out_res_in   = step ? step_res : out_res_ff;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.drive_low = out_res_ff.drive_low;
   assign rsp_bus.busy_res  = out_res_ff.busy_res;
   assign rsp_bus.done_res  = out_res_ff.done_res;
   assign rsp_bus.presence  = out_res_ff.presence;
   assign rsp_bus.read_byte = out_res_ff.read_byte;
   assign rsp_bus.rejected  = out_res_ff.rejected;

endmodule

// ----- dv/owbm_checker.sv -----
// ----------------------------------------------------------------------------
// owbm_checker: result checker of the 1-Wire bus master
// Follows register writes and tick transfers, works out the result of each
// tick with its own copy of the sequencer, and compares every result
// transfer field by field against the oldest result still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module owbm_checker
   import owbm_pkg::*;
#(
   parameter int TIMER_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   owbm_req_if                    req_mon,
   owbm_rsp_if                    rsp_mon,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_write_data,
   output int                     fail_count,
   output int                     pending,
   output logic                   seq_idle
);

   localparam int TIMER_MAX = (1 << TIMER_BITS) - 1;

   cfg_type                 cfg;
   op_type                  op;
   phase_type               ph;
   logic [TIMER_BITS-1:0]   timer;
   logic [BIT_CNT_W-1:0]    bit_cnt;
   logic [BYTE_W-1:0]       shreg;
   logic                    pres_seen;
   result_type              due_results[$];

   // phase length in ticks; a zero acts as one unless the phase may be skipped
   function automatic int span(logic [CFG_W-1:0] raw, bit zero_ok);
      int v;
      v = int'(raw);
      if (v == 0 && !zero_ok) v = 1;
      if (v > TIMER_MAX) v = TIMER_MAX;
      return v;
   endfunction

   function automatic void enter(phase_type p);
      ph    = p;
      timer = '0;
   endfunction

   // close one bit slot; true once the eighth bit is through
   function automatic logic close_slot();
      if (bit_cnt >= LAST_BIT) return 1'b1;
      bit_cnt = bit_cnt + BIT_CNT_W'(1);
      enter(PH_LOW);
      return 1'b0;
   endfunction

   function automatic result_type next_bus_result(item_type it);
      result_type r;
      logic       fin;
      r   = '0;
      fin = 1'b0;
      if (op != OP_IDLE && it.command != CMD_NONE) r.rejected = 1'b1;
      if (op == OP_IDLE && it.command != CMD_NONE) begin
         op        = op_type'(it.command);
         enter(PH_LOW);
         bit_cnt   = '0;
         pres_seen = 1'b0;
         shreg     = (it.command == CMD_WRITE) ? it.write_byte : '0;
      end
      if (op != OP_IDLE) begin
         r.busy_res = 1'b1;
         timer      = timer + TIMER_BITS'(1);
         case (op)
            OP_RESET: begin
               if (ph == PH_LOW) begin
                  r.drive_low = 1'b1;
                  if (int'(timer) >= span(cfg.reset_low_ticks, 1'b0)) enter(PH_MID);
               end else begin
                  if (int'(timer) == span(cfg.presence_sample_ticks, 1'b0))
                     pres_seen = ~it.line_level;
                  if (int'(timer) >= span(cfg.reset_release_ticks, 1'b0)) begin
                     fin        = 1'b1;
                     r.presence = pres_seen;
                  end
               end
            end
            OP_WRITE: begin
               if (ph == PH_LOW) begin
                  r.drive_low = 1'b1;
                  if (int'(timer) >= span(cfg.start_low_ticks, 1'b0)) enter(PH_MID);
               end else if (ph == PH_MID) begin
                  r.drive_low = ~shreg[0];
                  if (int'(timer) >= span(cfg.slot_ticks, 1'b0)) begin
                     shreg = shreg >> 1;
                     if (span(cfg.recovery_ticks, 1'b1) == 0) fin = close_slot();
                     else enter(PH_TAIL);
                  end
               end else begin
                  if (int'(timer) >= span(cfg.recovery_ticks, 1'b1)) fin = close_slot();
               end
            end
            default: begin
               if (ph == PH_LOW) begin
                  r.drive_low = 1'b1;
                  if (int'(timer) >= span(cfg.start_low_ticks, 1'b0)) enter(PH_MID);
               end else if (ph == PH_MID) begin
                  if (int'(timer) >= span(cfg.read_sample_ticks, 1'b0)) begin
                     shreg = {it.line_level, shreg[BYTE_W-1:1]};
                     enter(PH_TAIL);
                  end
               end else begin
                  if (int'(timer) >= span(cfg.slot_ticks, 1'b0)) begin
                     fin = close_slot();
                     if (fin) r.read_byte = shreg;
                  end
               end
            end
         endcase
         if (fin) begin
            op      = OP_IDLE;
            enter(PH_LOW);
            bit_cnt = '0;
         end
      end
      r.done_res = fin;
      return r;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      item_type   tick;
      result_type want;
      if (reset) begin
         cfg = '{RST_RESET_LOW, RST_PRES_SAMPLE, RST_RESET_RELEASE, RST_START_LOW,
                 RST_READ_SAMPLE, RST_SLOT, RST_RECOVERY};
         op        = OP_IDLE;
         ph        = PH_LOW;
         timer     = '0;
         bit_cnt   = '0;
         shreg     = '0;
         pres_seen = 1'b0;
         due_results.delete();
         fail_count = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_RESET_LOW:     cfg.reset_low_ticks       = csr_write_data;
               CSR_PRES_SAMPLE:   cfg.presence_sample_ticks = csr_write_data;
               CSR_RESET_RELEASE: cfg.reset_release_ticks   = csr_write_data;
               CSR_START_LOW:     cfg.start_low_ticks       = csr_write_data;
               CSR_READ_SAMPLE:   cfg.read_sample_ticks     = csr_write_data;
               CSR_SLOT:          cfg.slot_ticks            = csr_write_data;
               CSR_RECOVERY:      cfg.recovery_ticks        = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_results.size() == 0) begin
               fail_count++;
               $display("%0t: result transfer with none due, expected none actual %0h",
                        $time, {rsp_mon.drive_low, rsp_mon.busy_res, rsp_mon.done_res,
                                rsp_mon.presence, rsp_mon.read_byte, rsp_mon.rejected});
            end else begin
               want = due_results.pop_front();
               check_field("drive_low", int'(want.drive_low), int'(rsp_mon.drive_low));
               check_field("busy_res", int'(want.busy_res), int'(rsp_mon.busy_res));
               check_field("done_res", int'(want.done_res), int'(rsp_mon.done_res));
               check_field("presence", int'(want.presence), int'(rsp_mon.presence));
               check_field("read_byte", int'(want.read_byte), int'(rsp_mon.read_byte));
               check_field("rejected", int'(want.rejected), int'(rsp_mon.rejected));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            tick.command    = req_mon.command;
            tick.write_byte = req_mon.write_byte;
            tick.line_level = req_mon.line_level;
            due_results.push_back(next_bus_result(tick));
         end
      end
      pending  = due_results.size();
      seq_idle = (op == OP_IDLE);
   end

endmodule

// ----- dv/one_wire_bus_master_unit_test.sv -----
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit_test: testbench of the 1-Wire bus master
// Runs bus resets, byte writes and byte reads under mostly reset timing,
// then tiny, zero and late-sample timings, then random tick streams under
// random small timings, with bursty ticks and a stalling result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module one_wire_bus_master_unit_test;
   import owbm_pkg::*;

   localparam int TB_TIMER_BITS = 10;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RAND_PHASES   = 6;
   localparam int RAND_TICKS    = 50;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_write_data;

   int   fail_count;
   int   pending;
   logic seq_idle;
   int   burst_left = 0;
   int   quiet_cycles = 0;
   int   stall_mode = 0;
   int   stall_left = 0;
   int   stall_phase = 0;

   owbm_req_if req_bus ();
   owbm_rsp_if rsp_bus ();

   one_wire_bus_master_unit #(
      .TIMER_BITS(TB_TIMER_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   owbm_checker #(
      .TIMER_BITS(TB_TIMER_BITS)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .seq_idle        (seq_idle)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side: switch among always ready, coin flip, mostly ready and
   // a periodic stall
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      stall_phase = (stall_phase + 1) % 7;
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= 1'($urandom_range(0, 1));
         2: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
         default: rsp_bus.ready <= (stall_phase < 3);
      endcase
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // one tick transfer; entered and left at a falling edge
   task automatic send_tick(logic [1:0] cmd, logic [BYTE_W-1:0] data, logic lvl);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.write_byte <= data;
      req_bus.line_level <= lvl;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   function automatic logic pick_level(int line_mode);
      return (line_mode > 1) ? 1'($urandom_range(0, 1)) : (line_mode == 1);
   endfunction

   // start one operation and feed empty ticks until it completes;
   // line_mode 0 or 1 holds the bus level, anything else randomizes it
   task automatic run_op(logic [1:0] cmd, logic [BYTE_W-1:0] data, int line_mode);
      send_tick(cmd, data, pick_level(line_mode));
      while (!seq_idle) send_tick(CMD_NONE, 8'($urandom), pick_level(line_mode));
   endtask

   task automatic wind_down();
      while (!seq_idle) send_tick(CMD_NONE, 8'($urandom), 1'($urandom));
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one register write; the caller drops the write enable after the last one
   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CFG_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
   endtask

   task automatic load_config(cfg_type c);
      logic [CFG_W-1:0]       vals[7];
      logic [CSR_INDEX_W-1:0] regs[7];
      vals = '{c.reset_low_ticks, c.presence_sample_ticks, c.reset_release_ticks,
               c.start_low_ticks, c.read_sample_ticks, c.slot_ticks, c.recovery_ticks};
      regs = '{CSR_RESET_LOW, CSR_PRES_SAMPLE, CSR_RESET_RELEASE, CSR_START_LOW,
               CSR_READ_SAMPLE, CSR_SLOT, CSR_RECOVERY};
      for (int i = 0; i < 7; i++)
         write_reg(regs[i], vals[i]);
      csr_write_enable <= 1'b0;
   endtask

   task automatic retune(cfg_type c);
      wind_down();
      load_config(c);
   endtask

   function automatic cfg_type small_timing(int top);
      cfg_type c;
      c.reset_low_ticks       = CFG_W'($urandom_range(1, top));
      c.presence_sample_ticks = CFG_W'($urandom_range(1, top));
      c.reset_release_ticks   = CFG_W'($urandom_range(1, top));
      c.start_low_ticks       = CFG_W'($urandom_range(1, top));
      c.read_sample_ticks     = CFG_W'($urandom_range(1, top));
      c.slot_ticks            = CFG_W'($urandom_range(1, top));
      c.recovery_ticks        = CFG_W'($urandom_range(0, 3));
      return c;
   endfunction

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_NONE;
      req_bus.write_byte = '0;
      req_bus.line_level = 1'b1;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_RESET_LOW;
      csr_write_data     = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // shorten the reset pulse, the release period and the slot; the rest keeps its reset values
      write_reg(CSR_RESET_LOW, 10'd5);
      write_reg(CSR_RESET_RELEASE, 10'd70);
      write_reg(CSR_SLOT, 10'd3);
      csr_write_enable <= 1'b0;
      run_op(CMD_RESET, 8'h00, 0);
      run_op(CMD_WRITE, 8'hA5, 2);
      run_op(CMD_READ, 8'h00, 2);

      // one tick per phase; the second reset lands on the done tick
      retune('{10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd0});
      send_tick(CMD_RESET, 8'h00, 1'b0);
      send_tick(CMD_RESET, 8'hFF, 1'b0);
      send_tick(CMD_NONE, 8'hFF, 1'b1);
      run_op(CMD_RESET, 8'h00, 0);
      run_op(CMD_RESET, 8'hFF, 1);
      run_op(CMD_WRITE, 8'hFF, 1);
      run_op(CMD_WRITE, 8'h00, 0);
      run_op(CMD_READ, 8'h00, 1);
      run_op(CMD_READ, 8'hFF, 0);

      // zero lengths act as one, zero recovery skips the gap
      retune('0);
      run_op(CMD_WRITE, 8'h3C, 2);
      run_op(CMD_RESET, 8'h00, 0);
      run_op(CMD_READ, 8'h00, 2);

      // sample point past the end of the release period: no presence
      retune('{10'd3, 10'd9, 10'd4, 10'd1, 10'd2, 10'd3, 10'd1});
      run_op(CMD_RESET, 8'h00, 0);

      for (int p = 0; p < RAND_PHASES; p++) begin
         retune(small_timing((p == RAND_PHASES - 1) ? 12 : 6));
         repeat (RAND_TICKS) begin
            send_tick(($urandom_range(0, 11) == 0) ? 2'($urandom_range(1, 3)) : CMD_NONE,
                      8'($urandom), 1'($urandom));
         end
      end

      wind_down();
      if (fail_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
